@@ sv/owb_pkg.sv @@
// Shared types, constants and helpers of the one-wire bus master.
`timescale 1ns / 1ps

package owb_pkg;

    localparam int TIMER_W = 10;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 3;

    localparam int READ_SAMPLE_WAIT_DEF = 9;
    localparam int READ_TAIL_WAIT_DEF   = 55;

    // Register values after reset
    localparam logic [9:0] RESET_LOW_DEF      = 10'd500;
    localparam logic [7:0] PRESENCE_WAIT_DEF  = 8'd50;
    localparam logic [9:0] RESET_RECOV_DEF    = 10'd480;
    localparam logic [7:0] WR_ONE_LOW_DEF     = 8'd7;
    localparam logic [7:0] WR_ONE_HIGH_DEF    = 8'd64;
    localparam logic [7:0] WR_ZERO_LOW_DEF    = 8'd60;
    localparam logic [7:0] WR_ZERO_HIGH_DEF   = 8'd9;
    localparam logic [7:0] READ_LOW_DEF       = 8'd7;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_RECOV   = 3'd2,
        CFG_WR_ONE_LOW    = 3'd3,
        CFG_WR_ONE_HIGH   = 3'd4,
        CFG_WR_ZERO_LOW   = 3'd5,
        CFG_WR_ZERO_HIGH  = 3'd6,
        CFG_READ_LOW      = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_RECOV = 4'd3,
        PH_WR_LOW    = 4'd4,
        PH_WR_HIGH   = 4'd5,
        PH_RD_LOW    = 4'd6,
        PH_RD_WAIT   = 4'd7,
        PH_RD_TAIL   = 4'd8
    } t_phase;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [7:0] presence_wait;
        logic [9:0] reset_recov;
        logic [7:0] wr_one_low;
        logic [7:0] wr_one_high;
        logic [7:0] wr_zero_low;
        logic [7:0] wr_zero_high;
        logic [7:0] read_low;
    } t_cfg;

    typedef struct packed {
        logic              drive_low;
        logic              done;
        logic [BYTE_W-1:0] read_value;
        logic              presence_seen;
        logic              bus_stuck;
        logic              busy;
        logic              rejected;
    } t_result;

    // A zero tick count counts as one tick
    function automatic logic [TIMER_W-1:0] f_ticks(input logic [TIMER_W-1:0] t);
        return (t == '0) ? TIMER_W'(1) : t;
    endfunction

endpackage

@@ sv/one_wire_bus_master.sv @@
// Top level of the one-wire bus master: handshakes, timing registers and result register.
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_ready   i_kind, i_write_value, i_bus_level
//  out      source     o_out_valid / i_out_ready o_drive_low .. o_rejected
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One transaction in per cycle while results are taken; each gives one result, passing
//  through the input register, then the sequencer logic into the result register.
//  While a finished result waits, the input register takes one more transaction,
//  then the input stalls until the result is taken.
//  Synchronous active-low reset loads the timing registers with their defaults
//  and returns the sequencer to idle. Configuration is always ready.
`timescale 1ns / 1ps

module one_wire_bus_master
    import owb_pkg::*;
#(
    parameter int READ_SAMPLE_WAIT = READ_SAMPLE_WAIT_DEF,
    parameter int READ_TAIL_WAIT   = READ_TAIL_WAIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic [BYTE_W-1:0]    i_write_value,
    input  logic                 i_bus_level,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_drive_low,
    output logic                 o_done_res,
    output logic [BYTE_W-1:0]    o_read_value,
    output logic                 o_presence_seen,
    output logic                 o_bus_stuck,
    output logic                 o_busy_res,
    output logic                 o_rejected,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic              r_in_valid;
    logic [1:0]        r_kind;
    logic [BYTE_W-1:0] r_write_value;
    logic              r_bus_level;

    logic              r_out_valid;
    t_result           r_res;
    t_result           res;

    t_cfg              r_cfg;
    logic              step;

    // Move the held transaction into the result register when there is room
    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    // Write timing registers; bits above a register's width drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= RESET_LOW_DEF;
            r_cfg.presence_wait <= PRESENCE_WAIT_DEF;
            r_cfg.reset_recov   <= RESET_RECOV_DEF;
            r_cfg.wr_one_low    <= WR_ONE_LOW_DEF;
            r_cfg.wr_one_high   <= WR_ONE_HIGH_DEF;
            r_cfg.wr_zero_low   <= WR_ZERO_LOW_DEF;
            r_cfg.wr_zero_high  <= WR_ZERO_HIGH_DEF;
            r_cfg.read_low      <= READ_LOW_DEF;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data;
                CFG_PRESENCE_WAIT: r_cfg.presence_wait <= i_cfg_data[7:0];
                CFG_RESET_RECOV:   r_cfg.reset_recov   <= i_cfg_data;
                CFG_WR_ONE_LOW:    r_cfg.wr_one_low    <= i_cfg_data[7:0];
                CFG_WR_ONE_HIGH:   r_cfg.wr_one_high   <= i_cfg_data[7:0];
                CFG_WR_ZERO_LOW:   r_cfg.wr_zero_low   <= i_cfg_data[7:0];
                CFG_WR_ZERO_HIGH:  r_cfg.wr_zero_high  <= i_cfg_data[7:0];
                CFG_READ_LOW:      r_cfg.read_low      <= i_cfg_data[7:0];
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind        <= i_kind;
            r_write_value <= i_write_value;
            r_bus_level   <= i_bus_level;
        end
    end

    owb_core #(
        .READ_SAMPLE_WAIT (READ_SAMPLE_WAIT),
        .READ_TAIL_WAIT   (READ_TAIL_WAIT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_kind        (t_kind'(r_kind)),
        .i_write_value (r_write_value),
        .i_bus_level   (r_bus_level),
        .i_cfg         (r_cfg),
        .o_res         (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_low     = r_res.drive_low;
    assign o_done_res      = r_res.done;
    assign o_read_value    = r_res.read_value;
    assign o_presence_seen = r_res.presence_seen;
    assign o_bus_stuck     = r_res.bus_stuck;
    assign o_busy_res      = r_res.busy;
    assign o_rejected      = r_res.rejected;

endmodule

@@ sv/owb_core.sv @@
// Bus sequencer: phase, slot timer and shift byte, advanced one transaction at a time.
`timescale 1ns / 1ps

module owb_core
    import owb_pkg::*;
#(
    parameter int READ_SAMPLE_WAIT = READ_SAMPLE_WAIT_DEF,
    parameter int READ_TAIL_WAIT   = READ_TAIL_WAIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_kind             i_kind,
    input  logic [BYTE_W-1:0] i_write_value,
    input  logic              i_bus_level,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    localparam logic [TIMER_W-1:0] SAMPLE_TICKS = TIMER_W'(READ_SAMPLE_WAIT);
    localparam logic [TIMER_W-1:0] TAIL_TICKS   = TIMER_W'(READ_TAIL_WAIT);

    t_phase             r_phase,    n_phase;
    logic [TIMER_W-1:0] r_timer,    n_timer;
    logic [2:0]         r_bit,      n_bit;
    logic [BYTE_W-1:0]  r_shift,    n_shift;
    logic               r_presence, n_presence;

    logic [TIMER_W-1:0] timer_dec;
    logic [2:0]         bit_inc;

    assign timer_dec = r_timer - TIMER_W'(1);
    assign bit_inc   = r_bit + 3'd1;

    // Work out the next state and the result of this transaction
    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_presence = r_presence;
        o_res      = '0;

        if (r_phase == PH_IDLE) begin
            unique case (i_kind)
                KIND_TICK: begin
                end
                KIND_RESET: begin
                    n_bit   = 3'd0;
                    n_phase = PH_RST_LOW;
                    n_timer = f_ticks(i_cfg.reset_low);
                end
                KIND_WRITE: begin
                    n_bit   = 3'd0;
                    n_shift = i_write_value;
                    n_phase = PH_WR_LOW;
                    n_timer = i_write_value[0] ? f_ticks(TIMER_W'(i_cfg.wr_one_low))
                                               : f_ticks(TIMER_W'(i_cfg.wr_zero_low));
                end
                KIND_READ: begin
                    n_bit   = 3'd0;
                    n_shift = '0;
                    n_phase = PH_RD_LOW;
                    n_timer = f_ticks(TIMER_W'(i_cfg.read_low));
                end
            endcase
        end else begin
            // Commands while busy are dropped but still count as a tick
            o_res.rejected = (i_kind != KIND_TICK);
            n_timer = timer_dec;
            if (timer_dec == '0) begin
                unique case (r_phase)
                    PH_RST_LOW: begin
                        n_phase = PH_RST_WAIT;
                        n_timer = f_ticks(TIMER_W'(i_cfg.presence_wait));
                    end
                    PH_RST_WAIT: begin
                        n_presence = ~i_bus_level;
                        n_phase    = PH_RST_RECOV;
                        n_timer    = f_ticks(i_cfg.reset_recov);
                    end
                    PH_RST_RECOV: begin
                        o_res.bus_stuck = ~i_bus_level;
                        o_res.done      = 1'b1;
                        n_phase         = PH_IDLE;
                    end
                    PH_WR_LOW: begin
                        n_phase = PH_WR_HIGH;
                        n_timer = r_shift[r_bit] ? f_ticks(TIMER_W'(i_cfg.wr_one_high))
                                                 : f_ticks(TIMER_W'(i_cfg.wr_zero_high));
                    end
                    PH_WR_HIGH: begin
                        if (r_bit == 3'd7) begin
                            o_res.done = 1'b1;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_bit   = bit_inc;
                            n_phase = PH_WR_LOW;
                            n_timer = r_shift[bit_inc] ? f_ticks(TIMER_W'(i_cfg.wr_one_low))
                                                       : f_ticks(TIMER_W'(i_cfg.wr_zero_low));
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase = PH_RD_WAIT;
                        n_timer = f_ticks(SAMPLE_TICKS);
                    end
                    PH_RD_WAIT: begin
                        n_shift[r_bit] = r_shift[r_bit] | i_bus_level;
                        n_phase        = PH_RD_TAIL;
                        n_timer        = f_ticks(TAIL_TICKS);
                    end
                    PH_RD_TAIL: begin
                        if (r_bit == 3'd7) begin
                            o_res.done       = 1'b1;
                            o_res.read_value = r_shift;
                            n_phase          = PH_IDLE;
                        end else begin
                            n_bit   = bit_inc;
                            n_phase = PH_RD_LOW;
                            n_timer = f_ticks(TIMER_W'(i_cfg.read_low));
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            if (n_phase == PH_IDLE) begin
                n_timer = '0;
            end
        end

        o_res.drive_low     = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW)
                              || (n_phase == PH_RD_LOW);
        o_res.presence_seen = n_presence;
        o_res.busy          = (n_phase != PH_IDLE);
    end

    // Advance the sequencer on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
        end
    end

    // The timer is zero exactly when no sequence runs
    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_timer == '0))
        else $error("slot timer out of step with phase");

    // Hold phase, timer, bit and shift state between transactions
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_timer) && $stable(r_bit)
                    && $stable(r_shift))
        else $error("sequencer state moved without a transaction");

    // A completing transaction leaves the master idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done |=> r_phase == PH_IDLE)
        else $error("command completed but sequence still running");

    // Rejection only happens while a sequence runs
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.rejected |-> r_phase != PH_IDLE)
        else $error("command rejected while idle");

endmodule

@@ test/one_wire_bus_master_test.sv @@
// Self-checking testbench of the one-wire bus master: directed table, timing edge cases, then random soak.
`timescale 1ns / 1ps

module one_wire_bus_master_test;
    import owb_pkg::*;

    localparam int ITEMS_TARGET   = 600;
    localparam int QUIET_TAIL     = 250;
    localparam int PHASE_BUDGET   = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int N_ROWS         = 17;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG,
        ROW_RUN
    } t_row_op;

    typedef enum logic [1:0] {
        LVL_RANDOM,
        LVL_HIGH,
        LVL_LOW
    } t_lvl_mode;

    typedef struct packed {
        t_row_op    op;
        t_kind      kind;
        logic [7:0] wval;
        logic       lvl;
        logic       fixed;
        t_result    want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_kind;
    logic [BYTE_W-1:0]    i_write_value;
    logic                 i_bus_level;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_drive_low;
    logic                 o_done_res;
    logic [BYTE_W-1:0]    o_read_value;
    logic                 o_presence_seen;
    logic                 o_bus_stuck;
    logic                 o_busy_res;
    logic                 o_rejected;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Bus sequencer as the testbench sees it
    t_cfg               bus_cfg;
    t_phase             seq_phase;
    logic [TIMER_W-1:0] seq_timer;
    logic [2:0]         seq_bit;
    logic [7:0]         seq_byte;
    logic               seq_presence;

    t_result            status_q[$];
    logic [CFG_W-1:0]   timing [8];
    int                 mismatch_count;
    int                 sent_items;
    int                 soak_items;
    int                 gap_pct;
    bit                 hold_off_req;

    one_wire_bus_master dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_write_value   (i_write_value),
        .i_bus_level     (i_bus_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_low     (o_drive_low),
        .o_done_res      (o_done_res),
        .o_read_value    (o_read_value),
        .o_presence_seen (o_presence_seen),
        .o_bus_stuck     (o_bus_stuck),
        .o_busy_res      (o_busy_res),
        .o_rejected      (o_rejected),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Enter a phase; a zero count still lasts one tick
    function automatic void enter_phase(input t_phase p, input logic [TIMER_W-1:0] n);
        seq_phase = p;
        seq_timer = (n == '0) ? TIMER_W'(1) : n;
    endfunction

    function automatic void start_write_slot();
        enter_phase(PH_WR_LOW, seq_byte[seq_bit] ? TIMER_W'(bus_cfg.wr_one_low)
                                                 : TIMER_W'(bus_cfg.wr_zero_low));
    endfunction

    // Advance the sequencer by one item and return the status it shows afterwards
    function automatic t_result predict_status(input t_kind kind, input logic [7:0] wval,
                                               input logic lvl);
        t_result r;
        r = '0;
        if (seq_phase == PH_IDLE) begin
            if (kind != KIND_TICK) begin
                seq_bit = '0;
                case (kind)
                    KIND_RESET: enter_phase(PH_RST_LOW, bus_cfg.reset_low);
                    KIND_WRITE: begin
                        seq_byte = wval;
                        start_write_slot();
                    end
                    default: begin
                        seq_byte = '0;
                        enter_phase(PH_RD_LOW, TIMER_W'(bus_cfg.read_low));
                    end
                endcase
            end
        end else begin
            r.rejected = (kind != KIND_TICK);
            seq_timer = seq_timer - TIMER_W'(1);
            if (seq_timer == '0) begin
                case (seq_phase)
                    PH_RST_LOW: enter_phase(PH_RST_WAIT, TIMER_W'(bus_cfg.presence_wait));
                    PH_RST_WAIT: begin
                        seq_presence = !lvl;
                        enter_phase(PH_RST_RECOV, bus_cfg.reset_recov);
                    end
                    PH_RST_RECOV: begin
                        r.bus_stuck = !lvl;
                        r.done = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    PH_WR_LOW: begin
                        enter_phase(PH_WR_HIGH, seq_byte[seq_bit]
                                    ? TIMER_W'(bus_cfg.wr_one_high)
                                    : TIMER_W'(bus_cfg.wr_zero_high));
                    end
                    PH_WR_HIGH: begin
                        if (seq_bit == 3'd7) begin
                            r.done = 1'b1;
                            seq_phase = PH_IDLE;
                        end else begin
                            seq_bit = seq_bit + 3'd1;
                            start_write_slot();
                        end
                    end
                    PH_RD_LOW: enter_phase(PH_RD_WAIT, TIMER_W'(READ_SAMPLE_WAIT_DEF));
                    PH_RD_WAIT: begin
                        if (lvl) seq_byte[seq_bit] = 1'b1;
                        enter_phase(PH_RD_TAIL, TIMER_W'(READ_TAIL_WAIT_DEF));
                    end
                    PH_RD_TAIL: begin
                        if (seq_bit == 3'd7) begin
                            r.done = 1'b1;
                            r.read_value = seq_byte;
                            seq_phase = PH_IDLE;
                        end else begin
                            seq_bit = seq_bit + 3'd1;
                            enter_phase(PH_RD_LOW, TIMER_W'(bus_cfg.read_low));
                        end
                    end
                    default: seq_phase = PH_IDLE;
                endcase
            end
            if (seq_phase == PH_IDLE) seq_timer = '0;
        end
        r.drive_low = (seq_phase == PH_RST_LOW) || (seq_phase == PH_WR_LOW)
                   || (seq_phase == PH_RD_LOW);
        r.presence_seen = seq_presence;
        r.busy = (seq_phase != PH_IDLE);
        return r;
    endfunction

    // Status with no read byte, for rows whose outcome is plain to see;
    // flags are drive, done, presence, stuck, busy, rejected
    function automatic t_result bus_status(input logic [5:0] flags);
        t_result r;
        r = '0;
        {r.drive_low, r.done, r.presence_seen, r.bus_stuck, r.busy, r.rejected} = flags;
        return r;
    endfunction

    function automatic logic pick_level(input t_lvl_mode mode);
        case (mode)
            LVL_HIGH: return 1'b1;
            LVL_LOW:  return 1'b0;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Short timings; spare upper bits on the 8-bit registers must be ignored
    function automatic logic [CFG_W-1:0] pick_timing(input int idx);
        if (idx == CFG_RESET_LOW || idx == CFG_RESET_RECOV) begin
            return CFG_W'($urandom_range(0, 6));
        end else if ($urandom_range(0, 4) == 0) begin
            return CFG_W'($urandom_range(0, 40));
        end
        return {2'($urandom), 8'($urandom_range(0, 6))};
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Offer one item, hold it until taken, then record what it should produce
    task automatic send_item(input t_kind kind, input logic [7:0] wval, input logic lvl,
                             input logic fixed, input t_result want);
        t_result predicted;
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_write_value <= wval;
        i_bus_level   <= lvl;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_status(kind, wval, lvl);
        status_q.push_back(fixed ? want : predicted);
        sent_items++;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send(input t_kind kind, input logic [7:0] wval, input logic lvl);
        send_item(kind, wval, lvl, 1'b0, '0);
    endtask

    // Tick the running sequence to its end, with stray commands if asked
    task automatic run_to_idle(input t_lvl_mode mode, input logic noisy);
        t_kind k;
        while (seq_phase != PH_IDLE) begin
            k = KIND_TICK;
            if (noisy && $urandom_range(0, 19) == 0) k = t_kind'($urandom_range(1, 3));
            send(k, 8'($urandom), pick_level(mode));
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all eight timing registers from the timing array
    task automatic apply_timing();
        drain();
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= timing[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_idx'(i))
                CFG_RESET_LOW:     bus_cfg.reset_low     = timing[i];
                CFG_PRESENCE_WAIT: bus_cfg.presence_wait = timing[i][7:0];
                CFG_RESET_RECOV:   bus_cfg.reset_recov   = timing[i];
                CFG_WR_ONE_LOW:    bus_cfg.wr_one_low    = timing[i][7:0];
                CFG_WR_ONE_HIGH:   bus_cfg.wr_one_high   = timing[i][7:0];
                CFG_WR_ZERO_LOW:   bus_cfg.wr_zero_low   = timing[i][7:0];
                CFG_WR_ZERO_HIGH:  bus_cfg.wr_zero_high  = timing[i][7:0];
                default:           bus_cfg.read_low      = timing[i][7:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_q.size() == 0) begin
                $error("result transaction with no expectation waiting");
                mismatch_count++;
            end else begin
                want = status_q.pop_front();
                check_field("drive_low", 32'(want.drive_low), 32'(o_drive_low));
                check_field("done_res", 32'(want.done), 32'(o_done_res));
                check_field("read_value", 32'(want.read_value), 32'(o_read_value));
                check_field("presence_seen", 32'(want.presence_seen), 32'(o_presence_seen));
                check_field("bus_stuck", 32'(want.bus_stuck), 32'(o_bus_stuck));
                check_field("busy_res", 32'(want.busy), 32'(o_busy_res));
                check_field("rejected", 32'(want.rejected), 32'(o_rejected));
            end
        end
    end

    // Pace the result side: random stalls, and one long hold-off on request
    initial begin : sink_pacing
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // End the run if no transaction moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** one_wire_bus_master: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_row      plan [N_ROWS];
        t_lvl_mode mode;
        int        start;
        bit        first;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_TICK;
        i_write_value = '0;
        i_bus_level   = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        mismatch_count = 0;
        sent_items     = 0;
        soak_items     = 0;
        gap_pct        = 20;
        hold_off_req   = 1'b0;
        first          = 1'b1;

        bus_cfg = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_RECOV_DEF, WR_ONE_LOW_DEF,
                    WR_ONE_HIGH_DEF, WR_ZERO_LOW_DEF, WR_ZERO_HIGH_DEF, READ_LOW_DEF};
        seq_phase    = PH_IDLE;
        seq_timer    = '0;
        seq_bit      = '0;
        seq_byte     = '0;
        seq_presence = 1'b0;

        // Directed rows; after the timing write every configurable phase lasts a single tick
        plan = '{
            '{ROW_ITEM, KIND_TICK,  8'h00, 1'b1, 1'b1, bus_status(6'b000000)},
            '{ROW_ITEM, KIND_TICK,  8'hFF, 1'b0, 1'b1, bus_status(6'b000000)},
            '{ROW_CFG,  KIND_TICK,  8'h00, 1'b1, 1'b0, '0},
            '{ROW_ITEM, KIND_RESET, 8'hA5, 1'b1, 1'b1, bus_status(6'b100010)},
            '{ROW_ITEM, KIND_TICK,  8'h00, 1'b1, 1'b1, bus_status(6'b000010)},
            '{ROW_ITEM, KIND_READ,  8'h00, 1'b1, 1'b1, bus_status(6'b000011)},
            '{ROW_ITEM, KIND_TICK,  8'h00, 1'b1, 1'b1, bus_status(6'b010000)},
            '{ROW_ITEM, KIND_RESET, 8'h00, 1'b0, 1'b1, bus_status(6'b100010)},
            '{ROW_ITEM, KIND_WRITE, 8'hFF, 1'b0, 1'b1, bus_status(6'b000011)},
            '{ROW_ITEM, KIND_RESET, 8'h00, 1'b0, 1'b1, bus_status(6'b001011)},
            '{ROW_ITEM, KIND_TICK,  8'h00, 1'b0, 1'b1, bus_status(6'b011100)},
            '{ROW_ITEM, KIND_WRITE, 8'hFF, 1'b1, 1'b0, '0},
            '{ROW_RUN,  KIND_TICK,  8'h00, 1'b1, 1'b0, '0},
            '{ROW_ITEM, KIND_WRITE, 8'h00, 1'b0, 1'b0, '0},
            '{ROW_RUN,  KIND_TICK,  8'h00, 1'b0, 1'b0, '0},
            '{ROW_ITEM, KIND_TICK,  8'h00, 1'b1, 1'b0, '0},
            '{ROW_ITEM, KIND_READ,  8'hFF, 1'b1, 1'b1, bus_status(6'b101010)}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[r]) begin
            case (plan[r].op)
                ROW_CFG: begin
                    foreach (timing[i]) timing[i] = {2'b00, plan[r].wval};
                    apply_timing();
                end
                ROW_RUN: run_to_idle(plan[r].lvl ? LVL_HIGH : LVL_LOW, 1'b0);
                default: begin
                    send_item(plan[r].kind, plan[r].wval, plan[r].lvl, plan[r].fixed,
                              plan[r].want);
                end
            endcase
        end
        // Finish the read left open by the last row
        run_to_idle(LVL_RANDOM, 1'b1);

        // All-ones data puts the other 8-bit registers at their ceiling; reset ends and write timings kept short
        foreach (timing[i]) timing[i] = '1;
        timing[CFG_RESET_LOW]    = '0;
        timing[CFG_RESET_RECOV]  = '0;
        timing[CFG_WR_ONE_HIGH]  = '0;
        timing[CFG_WR_ZERO_LOW]  = '0;
        timing[CFG_WR_ZERO_HIGH] = '0;
        apply_timing();
        send(KIND_RESET, 8'($urandom), 1'b1);
        run_to_idle(LVL_RANDOM, 1'b1);

        // Long one bit among short zero bits, then a long zero bit among short one bits
        send(KIND_WRITE, 8'h80, 1'b1);
        run_to_idle(LVL_RANDOM, 1'b1);
        timing[CFG_WR_ONE_LOW]   = '0;
        timing[CFG_WR_ONE_HIGH]  = '0;
        timing[CFG_WR_ZERO_LOW]  = CFG_W'(40);
        timing[CFG_WR_ZERO_HIGH] = CFG_W'(40);
        apply_timing();
        send(KIND_WRITE, 8'h7F, 1'b1);
        run_to_idle(LVL_RANDOM, 1'b1);

        // Random soak: short timings, well-formed commands with stray ones mixed in
        while (soak_items < ITEMS_TARGET) begin
            gap_pct = (soak_items >= ITEMS_TARGET - QUIET_TAIL) ? 0
                                                                : 15 * $urandom_range(0, 2);
            foreach (timing[i]) timing[i] = pick_timing(i);
            apply_timing();
            if (first) begin
                // hold the result side off while items keep coming
                gap_pct = 0;
                hold_off_req = 1'b1;
                first = 1'b0;
            end
            start = sent_items;
            while (sent_items - start < PHASE_BUDGET) begin
                mode = t_lvl_mode'($urandom_range(0, 2));
                case ($urandom_range(0, 9))
                    0:       send(KIND_TICK, 8'($urandom), pick_level(mode));
                    1, 2, 3: send(KIND_RESET, 8'($urandom), pick_level(mode));
                    4, 5, 6: send(KIND_WRITE, 8'($urandom), pick_level(mode));
                    default: send(KIND_READ, 8'($urandom), pick_level(mode));
                endcase
                run_to_idle(mode, 1'b1);
            end
            soak_items += sent_items - start;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** one_wire_bus_master: PASSED **");
        end else begin
            $display("** one_wire_bus_master: FAILED **");
        end
        $finish;
    end

endmodule

@@ one_wire_bus_master.f @@
sv/owb_pkg.sv
sv/owb_core.sv
sv/one_wire_bus_master.sv
test/one_wire_bus_master_test.sv
